### sv/bst_pkg.sv
// Shared types and constants for the beacon signal table.
package bst_pkg;

  localparam int MAX_ENTRIES_DEF     = 5;
  localparam int LINE_LEN_DEF        = 100;
  localparam int ID_OFFSET_DEF       = 50;
  localparam int STRENGTH_OFFSET_DEF = 75;

  localparam int ID_CHARS    = 7;
  localparam int DIGIT_CHARS = 3;
  localparam int ID_W        = 8 * ID_CHARS;
  localparam int DIGITS_W    = 8 * DIGIT_CHARS;
  localparam int STRENGTH_W  = 8;
  localparam int TIME_W      = 32;
  localparam int COUNT_W     = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd60000;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic              func;
    logic [7:0]        rx_byte;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic                  best_valid;
    logic [ID_W-1:0]       best_id;
    logic [STRENGTH_W-1:0] best_strength;
    logic [COUNT_W-1:0]    entry_count;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_REPORT,
    CMD_UPDATE,
    CMD_SWEEP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [ID_W-1:0]       id;
    logic [STRENGTH_W-1:0] strength;
    logic [TIME_W-1:0]     now;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [STRENGTH_W-1:0] strength;
    logic [TIME_W-1:0]     stamp;
  } entry_t;

endpackage

### sv/bst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/bst_front.sv
// Front end: accepts items, tracks the report line and classifies each item into a command.
module bst_front import bst_pkg::*; #(
  parameter int LINE_LEN        = LINE_LEN_DEF,
  parameter int ID_OFFSET       = ID_OFFSET_DEF,
  parameter int STRENGTH_OFFSET = STRENGTH_OFFSET_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_push_data
);

  localparam int POS_W = $clog2(LINE_LEN);
  localparam int NEED  = (ID_OFFSET + ID_CHARS > STRENGTH_OFFSET + DIGIT_CHARS) ?
                         (ID_OFFSET + ID_CHARS) : (STRENGTH_OFFSET + DIGIT_CHARS);

  logic [POS_W-1:0]    line_pos_r, line_pos_nxt;
  logic [ID_W-1:0]     cap_id_r, cap_id_nxt;
  logic [DIGITS_W-1:0] cap_digits_r, cap_digits_nxt;
  logic [POS_W-1:0]    pos;
  logic                eol;
  logic                accept;
  logic                long_line;

  // digits in order, stop at first non-digit, value wraps mod 256
  function automatic logic [STRENGTH_W-1:0] parse_digits(input logic [DIGITS_W-1:0] d);
    logic [STRENGTH_W-1:0] v;
    logic [7:0]            c;
    logic                  stop;
    v    = '0;
    stop = 1'b0;
    for (int k = 0; k < DIGIT_CHARS; k++) begin
      c = d[8*(DIGIT_CHARS-1-k) +: 8];
      if (c < CHAR_ZERO || c > CHAR_NINE) begin
        stop = 1'b1;
      end
      if (!stop) begin
        v = STRENGTH_W'(v * 8'd10 + (c - CHAR_ZERO));
      end
    end
    return v;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  always_comb begin
    pos = (32'(line_pos_r) >= LINE_LEN - 1) ? '0 : line_pos_r;

    cap_id_nxt = cap_id_r;
    for (int k = 0; k < ID_CHARS; k++) begin
      if (32'(pos) == ID_OFFSET + k) begin
        cap_id_nxt[8*(ID_CHARS-1-k) +: 8] = in_data.rx_byte;
      end
    end
    cap_digits_nxt = cap_digits_r;
    for (int k = 0; k < DIGIT_CHARS; k++) begin
      if (32'(pos) == STRENGTH_OFFSET + k) begin
        cap_digits_nxt[8*(DIGIT_CHARS-1-k) +: 8] = in_data.rx_byte;
      end
    end

    eol       = (in_data.rx_byte == CHAR_CR) || (in_data.rx_byte == CHAR_LF);
    // terminator counts toward the length
    long_line = (32'(pos) + 1) >= NEED;

    line_pos_nxt = line_pos_r;
    if (accept && in_data.func == FUNC_BYTE) begin
      line_pos_nxt = eol ? '0 : (pos + POS_W'(1));
    end

    q_push_data.id       = cap_id_nxt;
    q_push_data.strength = parse_digits(cap_digits_nxt);
    q_push_data.now      = in_data.now_ms;
    if (in_data.func == FUNC_TICK) begin
      q_push_data.kind = CMD_SWEEP;
    end else if (eol && long_line) begin
      q_push_data.kind = CMD_UPDATE;
    end else begin
      q_push_data.kind = CMD_REPORT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_pos_r   <= '0;
      cap_id_r     <= '0;
      cap_digits_r <= '0;
    end else begin
      line_pos_r <= line_pos_nxt;
      if (accept && in_data.func == FUNC_BYTE) begin
        cap_id_r     <= cap_id_nxt;
        cap_digits_r <= cap_digits_nxt;
      end
    end
  end

endmodule

### sv/bst_queue.sv
// Short command queue between the front end and the table engine.
module bst_queue import bst_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> !full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && pop |=> $stable(count_r)) else $error("queue count moved on push and pop");
`endif

endmodule

### sv/bst_back.sv
// Table engine: carries out update, expiry and report commands and drives the result register.
module bst_back import bst_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  cmd_t              q_head,
  output logic              q_pop,
  input  logic [TIME_W-1:0] timeout_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD_RD,
    S_UPD_CHK,
    S_EVICT_RD,
    S_EVICT_WR,
    S_APPEND,
    S_SWP_RD,
    S_SWP_CHK,
    S_SWP_MOVE,
    S_BEST_RD,
    S_BEST_CHK,
    S_OUT
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0]      wmin_idx_r, wmin_idx_nxt;
  logic [STRENGTH_W-1:0] wmin_str_r, wmin_str_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [ID_W-1:0]       best_id_r, best_id_nxt;
  logic [STRENGTH_W-1:0] best_str_r, best_str_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  entry_t                  ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t                  rd_entry;
  entry_t                  new_entry;

  logic [CNT_W-1:0]  idx_ext;
  logic [CNT_W-1:0]  idx_p1;
  logic [IDX_W-1:0]  last_idx;
  logic              more;
  logic [TIME_W-1:0] age;
  logic              expired;
  logic              have_entries;

  bst_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry     = entry_t'(ram_rdata);
  assign new_entry    = '{id: cmd_r.id, strength: cmd_r.strength, stamp: cmd_r.now};
  assign idx_ext      = CNT_W'(idx_r);
  assign idx_p1       = idx_ext + CNT_W'(1);
  assign last_idx     = IDX_W'(cnt_r - CNT_W'(1));
  assign more         = idx_p1 < cnt_r;
  assign age          = cmd_r.now - rd_entry.stamp;
  assign expired      = age > timeout_ms;
  assign have_entries = (cnt_r != '0);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    wmin_idx_nxt  = wmin_idx_r;
    wmin_str_nxt  = wmin_str_r;
    cmd_nxt       = cmd_r;
    best_id_nxt   = best_id_r;
    best_str_nxt  = best_str_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = new_entry;
    ram_raddr     = idx_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head;
          idx_nxt = '0;
          case (q_head.kind)
            CMD_UPDATE: state_nxt = have_entries ? S_UPD_RD : S_APPEND;
            CMD_SWEEP:  state_nxt = have_entries ? S_SWP_RD : S_BEST_RD;
            default:    state_nxt = S_OUT;
          endcase
        end
      end
      S_UPD_RD: begin
        state_nxt = S_UPD_CHK;
      end
      S_UPD_CHK: begin
        // look ahead one entry while checking this one
        ram_raddr = IDX_W'(idx_p1);
        if (rd_entry.id == cmd_r.id) begin
          ram_we    = 1'b1;
          state_nxt = S_BEST_RD;
        end else begin
          if (idx_r == '0 || rd_entry.strength < wmin_str_r) begin
            wmin_idx_nxt = idx_r;
            wmin_str_nxt = rd_entry.strength;
          end
          if (more) begin
            idx_nxt = IDX_W'(idx_p1);
          end else if (32'(cnt_r) < MAX_ENTRIES) begin
            state_nxt = S_APPEND;
          end else begin
            state_nxt = S_EVICT_RD;
          end
        end
      end
      S_EVICT_RD: begin
        ram_raddr = last_idx;
        state_nxt = S_EVICT_WR;
      end
      S_EVICT_WR: begin
        // weakest slot takes the last entry
        ram_we    = 1'b1;
        ram_waddr = wmin_idx_r;
        ram_wdata = rd_entry;
        cnt_nxt   = cnt_r - CNT_W'(1);
        state_nxt = S_APPEND;
      end
      S_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(cnt_r);
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_BEST_RD;
      end
      S_SWP_RD: begin
        state_nxt = S_SWP_CHK;
      end
      S_SWP_CHK: begin
        if (expired) begin
          ram_raddr = last_idx;
          state_nxt = S_SWP_MOVE;
        end else begin
          ram_raddr = IDX_W'(idx_p1);
          if (more) begin
            idx_nxt = IDX_W'(idx_p1);
          end else begin
            state_nxt = S_BEST_RD;
          end
        end
      end
      S_SWP_MOVE: begin
        // same slot is checked again after the move
        ram_we    = 1'b1;
        ram_wdata = rd_entry;
        cnt_nxt   = cnt_r - CNT_W'(1);
        state_nxt = (idx_ext < cnt_r - CNT_W'(1)) ? S_SWP_RD : S_BEST_RD;
      end
      S_BEST_RD: begin
        ram_raddr = '0;
        idx_nxt   = '0;
        if (have_entries) begin
          state_nxt = S_BEST_CHK;
        end else begin
          best_id_nxt  = '0;
          best_str_nxt = '0;
          state_nxt    = S_OUT;
        end
      end
      S_BEST_CHK: begin
        ram_raddr = IDX_W'(idx_p1);
        if (idx_r == '0 || rd_entry.strength > best_str_r) begin
          best_id_nxt  = rd_entry.id;
          best_str_nxt = rd_entry.strength;
        end
        if (more) begin
          idx_nxt = IDX_W'(idx_p1);
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.best_valid    = have_entries;
          out_data_nxt.best_id       = have_entries ? best_id_r : '0;
          out_data_nxt.best_strength = have_entries ? best_str_r : '0;
          out_data_nxt.entry_count   = COUNT_W'(cnt_r);
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wmin_idx_r <= wmin_idx_nxt;
    wmin_str_r <= wmin_str_nxt;
    cmd_r      <= cmd_nxt;
    best_id_r  <= best_id_nxt;
    best_str_r <= best_str_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= MAX_ENTRIES) else $error("entry count beyond table size");
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> 32'(ram_waddr) < MAX_ENTRIES) else $error("table write out of range");
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.best_valid |->
      out_data_r.best_id == '0 && out_data_r.best_strength == '0)
    else $error("empty table reported a best entry");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE && !q_empty) else $error("command taken while busy");
`endif

endmodule

### sv/beacon_signal_table.sv
// Top level of the beacon signal table: front end, command queue, table engine.
//
// Input channel (in_valid / in_stall / in_data): one item per transaction, either
// a received byte (func = 0) or a periodic tick (func = 1), each with now_ms.
// Result channel (out_valid / out_stall / out_data): exactly one result per
// input item, in order: strongest entry, its id and strength, and entry count.
// Configuration: cfg_we with cfg_wdata writes timeout_ms; write only while idle.
// A byte that does not complete a long line passes through the command queue
// and the S_OUT state into the result register. A line end walks the table twice
// (match/weakest search, then strongest search), one entry per cycle. A tick
// checks each entry for expiry, moving the last entry into each expired slot and
// checking that slot again, then runs the strongest search.
// A two-entry command queue lets the front accept items while the engine works;
// in_stall rises only when that queue is full.
// A stalled result holds in the output register; the engine waits on it only
// when the next result is ready.
// Reset (rst_n low, synchronous) empties the table and queue, restarts the line
// and sets timeout_ms to 60000.
module beacon_signal_table import bst_pkg::*; #(
  parameter int MAX_ENTRIES     = MAX_ENTRIES_DEF,
  parameter int LINE_LEN        = LINE_LEN_DEF,
  parameter int ID_OFFSET       = ID_OFFSET_DEF,
  parameter int STRENGTH_OFFSET = STRENGTH_OFFSET_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata
);

  logic [TIME_W-1:0] timeout_r;
  logic              q_push;
  cmd_t              q_push_data;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  cmd_t              q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  bst_front #(
    .LINE_LEN        (LINE_LEN),
    .ID_OFFSET       (ID_OFFSET),
    .STRENGTH_OFFSET (STRENGTH_OFFSET)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  bst_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  bst_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .timeout_ms (timeout_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

### sim/tb_beacon_signal_table.sv
// Self-checking testbench for beacon_signal_table: report lines, ticks and timeout settings.
module tb_beacon_signal_table;
  timeunit 1ns;
  timeprecision 1ps;
  import bst_pkg::*;

  localparam int LINE_NEED = (ID_OFFSET_DEF + ID_CHARS > STRENGTH_OFFSET_DEF + DIGIT_CHARS) ?
                             ID_OFFSET_DEF + ID_CHARS : STRENGTH_OFFSET_DEF + DIGIT_CHARS;
  localparam int ID_POOL      = 7;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 40;
  localparam int LIMIT_CYCLES = 600000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // Tracks the beacon table and line capture; queues the strongest-entry report per item.
  class beacon_tracker;
    logic [TIME_W-1:0]     timeout;
    logic [ID_W-1:0]       ids [MAX_ENTRIES_DEF];
    logic [STRENGTH_W-1:0] levels [MAX_ENTRIES_DEF];
    logic [TIME_W-1:0]     stamps [MAX_ENTRIES_DEF];
    int                    live;
    int                    line_at;
    logic [ID_W-1:0]       cap_id;
    logic [DIGITS_W-1:0]   cap_digits;
    out_item_t             expected_reports [$];
    int                    errors;

    function new();
      timeout    = TIMEOUT_RESET;
      live       = 0;
      line_at    = 0;
      cap_id     = '0;
      cap_digits = '0;
      errors     = 0;
      foreach (ids[i]) begin
        ids[i]    = '0;
        levels[i] = '0;
        stamps[i] = '0;
      end
    endfunction

    function void drop_into(int slot);
      int last;
      last         = live - 1;
      ids[slot]    = ids[last];
      levels[slot] = levels[last];
      stamps[slot] = stamps[last];
      live         = last;
    endfunction

    // digits stop at the first non-digit; value wraps mod 256
    function logic [STRENGTH_W-1:0] digit_value();
      logic [STRENGTH_W-1:0] v;
      logic [7:0]            c;
      bit                    stop;
      v    = '0;
      stop = 1'b0;
      for (int k = 0; k < DIGIT_CHARS; k++) begin
        c = cap_digits[8*(DIGIT_CHARS-1-k) +: 8];
        if (c < CHAR_ZERO || c > CHAR_NINE) stop = 1'b1;
        if (!stop) v = v * 8'd10 + 8'(c - CHAR_ZERO);
      end
      return v;
    endfunction

    function void refresh(logic [ID_W-1:0] id, logic [STRENGTH_W-1:0] lvl,
                          logic [TIME_W-1:0] now);
      int weakest;
      for (int i = 0; i < live; i++) begin
        if (ids[i] == id) begin
          levels[i] = lvl;
          stamps[i] = now;
          return;
        end
      end
      if (live >= MAX_ENTRIES_DEF) begin
        weakest = 0;
        for (int i = 1; i < live; i++)
          if (levels[i] < levels[weakest]) weakest = i;
        drop_into(weakest);
      end
      ids[live]    = id;
      levels[live] = lvl;
      stamps[live] = now;
      live++;
    endfunction

    function void take_byte(logic [7:0] b, logic [TIME_W-1:0] now);
      int p;
      if (line_at >= LINE_LEN_DEF - 1) line_at = 0;
      p = line_at;
      line_at++;
      if (p >= ID_OFFSET_DEF && p < ID_OFFSET_DEF + ID_CHARS)
        cap_id[8*(ID_CHARS-1-(p-ID_OFFSET_DEF)) +: 8] = b;
      if (p >= STRENGTH_OFFSET_DEF && p < STRENGTH_OFFSET_DEF + DIGIT_CHARS)
        cap_digits[8*(DIGIT_CHARS-1-(p-STRENGTH_OFFSET_DEF)) +: 8] = b;
      if (b == CHAR_CR || b == CHAR_LF) begin
        // terminator counts toward the length
        if (line_at >= LINE_NEED) refresh(cap_id, digit_value(), now);
        line_at = 0;
      end
    endfunction

    function void sweep(logic [TIME_W-1:0] now);
      int                i;
      logic [TIME_W-1:0] age;
      i = 0;
      while (i < live) begin
        age = now - stamps[i];
        if (age > timeout) drop_into(i);
        else i++;
      end
    endfunction

    function void note_item(in_item_t it);
      out_item_t r;
      int        s;
      if (it.func == FUNC_TICK) sweep(it.now_ms);
      else take_byte(it.rx_byte, it.now_ms);
      r = '0;
      if (live > 0) begin
        s = 0;
        for (int i = 1; i < live; i++)
          if (levels[i] > levels[s]) s = i;
        r.best_valid    = 1'b1;
        r.best_id       = ids[s];
        r.best_strength = levels[s];
      end
      r.entry_count = COUNT_W'(live);
      expected_reports.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: result with nothing pending, expected none got %h", $time, got);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("best_valid", want.best_valid, got.best_valid);
      compare_field("best_id", want.best_id, got.best_id);
      compare_field("best_strength", want.best_strength, got.best_strength);
      compare_field("entry_count", want.entry_count, got.entry_count);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_we = 1'b0;
  logic [TIME_W-1:0] cfg_wdata = '0;

  beacon_tracker     tracker = new();
  int                send_idle_pct = 0;
  int                stall_pct = 0;
  bit                hold_req = 1'b0;
  int                hold_left = 0;
  int                items_sent = 0;
  int                cycles = 0;
  int                step_ms = 20;
  int                next_fresh = 0;
  logic [TIME_W-1:0] clock_ms = 32'hFFFF_E000;
  logic [DIGITS_W-1:0] last_digits = "000";
  logic [ID_W-1:0]   id_pool [ID_POOL];

  beacon_signal_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.note_item(in_data);
      if (out_valid && !out_stall) tracker.check_report(out_data);
    end
  end

  // result side: random stall, plus a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_item(input logic f, input logic [7:0] b, input logic [TIME_W-1:0] now);
    in_item_t it;
    it.func    = f;
    it.rx_byte = b;
    it.now_ms  = now;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  function void advance_ms();
    if ($urandom_range(199) == 0) clock_ms += $urandom;
    else clock_ms += $urandom_range(step_ms);
  endfunction

  task automatic send_tick();
    advance_ms();
    send_item(FUNC_TICK, 8'($urandom), clock_ms);
  endtask

  // time only matters at a line end, so other bytes carry random stamps
  task automatic put_char(input logic [7:0] b);
    if ($urandom_range(99) < 3) send_tick();
    if (b == CHAR_CR || b == CHAR_LF) begin
      advance_ms();
      send_item(FUNC_BYTE, b, clock_ms);
    end else begin
      send_item(FUNC_BYTE, b, $urandom);
    end
  endtask

  function logic [7:0] digit_char();
    return 8'(CHAR_ZERO + $urandom_range(9));
  endfunction

  function logic [7:0] other_char();
    return 8'($urandom_range(47, 32));
  endfunction

  task automatic send_report_line();
    logic [ID_W-1:0]     id;
    logic [DIGITS_W-1:0] dig;
    int                  len;
    int                  pick;
    if ($urandom_range(9) < 7) begin
      id         = id_pool[next_fresh];
      next_fresh = (next_fresh + 1) % ID_POOL;
    end else begin
      id = id_pool[$urandom_range(ID_POOL-1)];
    end
    case ($urandom_range(7))
      0: dig = "000";
      1: dig = "255";
      2: dig = "256";
      3: dig = "999";
      4: dig = last_digits;
      5: dig = {digit_char(), digit_char(), other_char()};
      6: dig = {other_char(), digit_char(), digit_char()};
      default: dig = {digit_char(), digit_char(), digit_char()};
    endcase
    last_digits = dig;
    // len = bytes before the terminator: one short, exactly minimal, overflowing, normal
    pick = $urandom_range(19);
    if (pick == 0) len = LINE_NEED - 2;
    else if (pick == 1) len = LINE_NEED - 1;
    else if (pick == 2) len = LINE_LEN_DEF - 1 + $urandom_range(30);
    else len = LINE_NEED + $urandom_range(LINE_LEN_DEF - 2 - LINE_NEED);
    for (int p = 0; p < len; p++) begin
      if (p >= ID_OFFSET_DEF && p < ID_OFFSET_DEF + ID_CHARS)
        put_char(id[8*(ID_CHARS-1-(p-ID_OFFSET_DEF)) +: 8]);
      else if (p >= STRENGTH_OFFSET_DEF && p < STRENGTH_OFFSET_DEF + DIGIT_CHARS)
        put_char(dig[8*(DIGIT_CHARS-1-(p-STRENGTH_OFFSET_DEF)) +: 8]);
      else
        put_char(8'($urandom_range(126, 32)));
    end
    put_char($urandom_range(1) ? CHAR_CR : CHAR_LF);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(6, 1);
    for (int k = 0; k < n; k++) put_char(8'($urandom));
    put_char($urandom_range(1) ? CHAR_CR : CHAR_LF);
  endtask

  task automatic write_timeout(input logic [TIME_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tracker.timeout = v;
  endtask

  task automatic run_phase(input logic [TIME_W-1:0] tmo, input bit set_tmo,
                           input idle_mode_t mode, input int budget, input int step,
                           input bit squeeze);
    int start;
    if (set_tmo) write_timeout(tmo);
    send_idle_pct = (mode == IDLE_SEND) ? 56 : (mode == IDLE_BOTH) ? 15 : 0;
    stall_pct     = (mode == IDLE_RECV) ? 56 : (mode == IDLE_BOTH) ? 15 : 0;
    step_ms       = step;
    if (squeeze) hold_req = 1'b1;
    start = items_sent;
    while (items_sent - start < budget) begin
      if ($urandom_range(4) == 0) send_noise();
      else send_report_line();
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.expected_reports.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] b;
    for (int i = 0; i < ID_POOL; i++) begin
      for (int k = 0; k < ID_CHARS; k++) begin
        do b = 8'($urandom); while (b == CHAR_CR || b == CHAR_LF);
        id_pool[i][8*k +: 8] = b;
      end
    end
    id_pool[0] = '0;
    // two ids that differ only in the last character
    id_pool[1] = {id_pool[1][ID_W-1:8], 8'h42};
    id_pool[2] = {id_pool[1][ID_W-1:8], 8'h41};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table, field extremes, bare terminators, tick ignoring its byte
    send_item(FUNC_TICK, 8'h00, 32'h0000_0000);
    send_item(FUNC_TICK, CHAR_CR, 32'hFFFF_FFFF);
    send_item(FUNC_BYTE, 8'h00, 32'h0000_0000);
    send_item(FUNC_BYTE, 8'hFF, 32'hFFFF_FFFF);
    send_item(FUNC_BYTE, 8'h55, 32'h5555_5555);
    send_item(FUNC_BYTE, 8'hAA, 32'hAAAA_AAAA);
    send_item(FUNC_BYTE, CHAR_CR, 32'h0000_0001);
    send_item(FUNC_BYTE, CHAR_LF, 32'h8000_0000);
    send_item(FUNC_TICK, 8'hFF, clock_ms);

    // each phase overshoots its budget by part of a line
    run_phase(TIMEOUT_RESET, 1'b0, IDLE_NONE, 215, 40, 1'b1);
    run_phase(32'hFFFF_FFFF, 1'b1, IDLE_SEND, 215, 400, 1'b0);
    run_phase(32'd1, 1'b1, IDLE_RECV, 135, 3, 1'b0);
    run_phase(32'd0, 1'b1, IDLE_BOTH, 135, 1, 1'b0);
    run_phase(32'($urandom_range(5000, 100)), 1'b1, IDLE_NONE, 135, 200, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0t: %0d errors, %0d results outstanding", $time, tracker.errors,
               tracker.expected_reports.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
